/* rtl/core/neander_accumulator_cpu_core_defines.svh */
`ifndef NEANDER_ACCUMULATOR_CPU_CORE_DEFINES_SVH
`define NEANDER_ACCUMULATOR_CPU_CORE_DEFINES_SVH

// check that holds in the same cycle as the trigger
`define NACC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check that holds in the cycle after the trigger
`define NACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/nacc_pkg.sv */
`timescale 1ns / 1ps
package nacc_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int DATA_W    = 8;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;
   localparam logic [1:0] REQ_STEP  = 2'd3;

   localparam logic [DATA_W-1:0] OP_NOP = 8'h00;
   localparam logic [DATA_W-1:0] OP_STA = 8'h10;
   localparam logic [DATA_W-1:0] OP_LDA = 8'h20;
   localparam logic [DATA_W-1:0] OP_ADD = 8'h30;
   localparam logic [DATA_W-1:0] OP_OR  = 8'h40;
   localparam logic [DATA_W-1:0] OP_AND = 8'h50;
   localparam logic [DATA_W-1:0] OP_NOT = 8'h60;
   localparam logic [DATA_W-1:0] OP_JMP = 8'h80;
   localparam logic [DATA_W-1:0] OP_JN  = 8'h90;
   localparam logic [DATA_W-1:0] OP_JZ  = 8'hA0;
   localparam logic [DATA_W-1:0] OP_HLT = 8'hF0;

   localparam logic [ADDR_W-1:0] START_ACC_ADDR = 8'h01;
   localparam logic [ADDR_W-1:0] START_PC_ADDR  = 8'h02;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_OR,
      ALU_AND,
      ALU_NOT,
      ALU_PASS
   } alu_op_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   function automatic alu_op_type alu_op_of(input logic [DATA_W-1:0] opcode);
      alu_op_type op;
      unique case (opcode)
         OP_ADD:  op = ALU_ADD;
         OP_OR:   op = ALU_OR;
         OP_AND:  op = ALU_AND;
         default: op = ALU_PASS;
      endcase
      return op;
   endfunction

endpackage

/* rtl/core/nacc_req_if.sv */
`timescale 1ns / 1ps
interface nacc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] address;
   logic [7:0] data;

   modport source (output valid, output req_type, output address, output data, input ready);
   modport sink (input valid, input req_type, input address, input data, output ready);
endinterface

/* rtl/core/nacc_rsp_if.sv */
`timescale 1ns / 1ps
interface nacc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] accumulator;
   logic [7:0] program_counter;
   logic       negative_flag;
   logic       zero_flag;
   logic       halted;
   logic [7:0] read_data;

   modport source (
      output valid, output accumulator, output program_counter, output negative_flag,
      output zero_flag, output halted, output read_data, input ready
   );
   modport sink (
      input valid, input accumulator, input program_counter, input negative_flag,
      input zero_flag, input halted, input read_data, output ready
   );
endinterface

/* rtl/core/nacc_mem.sv */
`timescale 1ns / 1ps
module nacc_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  nacc_pkg::mem_req_type      mem_req,
   output logic [nacc_pkg::DATA_W-1:0] rdata
);

   logic [nacc_pkg::DATA_W-1:0]    mem_array [nacc_pkg::MEM_DEPTH];
   logic [nacc_pkg::MEM_DEPTH-1:0] valid_ff;
   logic [nacc_pkg::DATA_W-1:0]    rdata_ff;
   logic                           rvalid_ff;

   // bytes never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.we) begin
         valid_ff[mem_req.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff  <= mem_array[mem_req.addr];
      rvalid_ff <= valid_ff[mem_req.addr];
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

/* rtl/core/nacc_alu.sv */
`timescale 1ns / 1ps
module nacc_alu (
   input  nacc_pkg::alu_op_type         op,
   input  logic [nacc_pkg::DATA_W-1:0]  a,
   input  logic [nacc_pkg::DATA_W-1:0]  b,
   output logic [nacc_pkg::DATA_W-1:0]  y
);

   always_comb begin
      unique case (op)
         nacc_pkg::ALU_ADD:  y = a + b;
         nacc_pkg::ALU_OR:   y = a | b;
         nacc_pkg::ALU_AND:  y = a & b;
         nacc_pkg::ALU_NOT:  y = ~a;
         nacc_pkg::ALU_PASS: y = b;
         default:            y = b;
      endcase
   end

endmodule

/* rtl/core/neander_accumulator_cpu_core.sv */
// states after a beat: write done; read rd_data, done; start st_acc, st_pc, done
// step: fetch, opnd, exec for lda/add/or/and (extra data read), done; halted: done alone
// one request at a time; the single-port byte memory with registered read sets the states
// result register frees the input side as soon as the result is loaded
// reset (synchronous, active high) clears acc, pc, flags, halt mark and all memory bytes
`timescale 1ns / 1ps
`include "neander_accumulator_cpu_core_defines.svh"
module neander_accumulator_cpu_core (
   input  logic       clock,
   input  logic       reset,
   nacc_req_if.sink   req_chan,
   nacc_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_DATA,
      S_ST_ACC,
      S_ST_PC,
      S_FETCH,
      S_OPND,
      S_EXEC,
      S_DONE
   } state_type;

   state_type                   state_ff;
   logic [nacc_pkg::DATA_W-1:0] acc_ff;
   logic [nacc_pkg::ADDR_W-1:0] pc_ff;
   logic [nacc_pkg::ADDR_W-1:0] pc1_ff;
   logic [nacc_pkg::DATA_W-1:0] op_ff;
   logic [nacc_pkg::DATA_W-1:0] rd_ff;
   logic                        neg_ff;
   logic                        zero_ff;
   logic                        halt_ff;

   logic [nacc_pkg::DATA_W-1:0] out_acc_ff;
   logic [nacc_pkg::ADDR_W-1:0] out_pc_ff;
   logic [nacc_pkg::DATA_W-1:0] out_rd_ff;
   logic                        out_neg_ff;
   logic                        out_zero_ff;
   logic                        out_halt_ff;
   logic                        rsp_valid_ff;

   nacc_pkg::mem_req_type       mem_req;
   logic [nacc_pkg::DATA_W-1:0] mem_rdata;
   nacc_pkg::alu_op_type        alu_op;
   logic [nacc_pkg::DATA_W-1:0] alu_a;
   logic [nacc_pkg::DATA_W-1:0] alu_b;
   logic [nacc_pkg::DATA_W-1:0] alu_y;
   logic                        req_beat;
   logic                        rsp_free;
   logic                        rsp_load;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load       = (state_ff == S_DONE) && rsp_free;

   nacc_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   nacc_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // one memory port shared by requests, fetch, operand and data accesses
   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.addr  = pc_ff;
      mem_req.wdata = acc_ff;
      unique case (state_ff)
         S_IDLE: begin
            unique case (req_chan.req_type)
               nacc_pkg::REQ_WRITE: begin
                  mem_req.we    = req_beat;
                  mem_req.addr  = req_chan.address;
                  mem_req.wdata = req_chan.data;
               end
               nacc_pkg::REQ_READ:  mem_req.addr = req_chan.address;
               nacc_pkg::REQ_START: mem_req.addr = nacc_pkg::START_ACC_ADDR;
               nacc_pkg::REQ_STEP:  mem_req.addr = pc_ff;
               default:             mem_req.addr = pc_ff;
            endcase
         end
         S_ST_ACC: mem_req.addr = nacc_pkg::START_PC_ADDR;
         S_FETCH:  mem_req.addr = alu_y;
         S_OPND: begin
            // operand byte is on the read port now
            mem_req.we   = (op_ff == nacc_pkg::OP_STA);
            mem_req.addr = mem_rdata;
         end
         default: mem_req.addr = pc_ff;
      endcase
   end

   // shared unit: pc increments, then the accumulator operation
   always_comb begin
      alu_op = nacc_pkg::ALU_ADD;
      alu_a  = pc1_ff;
      alu_b  = 8'd1;
      unique case (state_ff)
         S_FETCH: alu_a = pc_ff;
         S_OPND: begin
            if (op_ff == nacc_pkg::OP_NOT) begin
               alu_op = nacc_pkg::ALU_NOT;
               alu_a  = acc_ff;
            end
         end
         S_EXEC: begin
            alu_op = nacc_pkg::alu_op_of(op_ff);
            alu_a  = acc_ff;
            alu_b  = mem_rdata;
         end
         default: alu_a = pc1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         neg_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  rd_ff <= '0;
                  unique case (req_chan.req_type)
                     nacc_pkg::REQ_WRITE: state_ff <= S_DONE;
                     nacc_pkg::REQ_READ:  state_ff <= S_RD_DATA;
                     nacc_pkg::REQ_START: state_ff <= S_ST_ACC;
                     nacc_pkg::REQ_STEP:  state_ff <= halt_ff ? S_DONE : S_FETCH;
                     default:             state_ff <= S_DONE;
                  endcase
               end
            end
            S_RD_DATA: begin
               rd_ff    <= mem_rdata;
               state_ff <= S_DONE;
            end
            S_ST_ACC: begin
               acc_ff   <= mem_rdata;
               state_ff <= S_ST_PC;
            end
            S_ST_PC: begin
               pc_ff    <= mem_rdata;
               neg_ff   <= 1'b0;
               zero_ff  <= 1'b0;
               halt_ff  <= 1'b0;
               state_ff <= S_DONE;
            end
            S_FETCH: begin
               op_ff    <= mem_rdata;
               pc1_ff   <= alu_y;
               state_ff <= S_OPND;
            end
            S_OPND: begin
               // data operand instructions need one more read
               if (op_ff == nacc_pkg::OP_LDA || op_ff == nacc_pkg::OP_ADD ||
                   op_ff == nacc_pkg::OP_OR || op_ff == nacc_pkg::OP_AND) begin
                  state_ff <= S_EXEC;
               end else begin
                  state_ff <= S_DONE;
               end
               unique case (op_ff)
                  nacc_pkg::OP_STA: begin
                     pc_ff   <= alu_y;
                     neg_ff  <= acc_ff[7];
                     zero_ff <= (acc_ff == '0);
                  end
                  nacc_pkg::OP_LDA, nacc_pkg::OP_ADD, nacc_pkg::OP_OR, nacc_pkg::OP_AND: begin
                     pc_ff <= alu_y;
                  end
                  nacc_pkg::OP_NOT: begin
                     acc_ff  <= alu_y;
                     neg_ff  <= alu_y[7];
                     zero_ff <= (alu_y == '0);
                     pc_ff   <= pc1_ff;
                  end
                  nacc_pkg::OP_JMP: begin
                     pc_ff   <= mem_rdata;
                     neg_ff  <= acc_ff[7];
                     zero_ff <= (acc_ff == '0);
                  end
                  nacc_pkg::OP_JN: begin
                     pc_ff   <= neg_ff ? mem_rdata : alu_y;
                     neg_ff  <= acc_ff[7];
                     zero_ff <= (acc_ff == '0);
                  end
                  nacc_pkg::OP_JZ: begin
                     pc_ff   <= zero_ff ? mem_rdata : alu_y;
                     neg_ff  <= acc_ff[7];
                     zero_ff <= (acc_ff == '0);
                  end
                  nacc_pkg::OP_HLT: halt_ff <= 1'b1;
                  default: begin
                     // nop and unknown opcodes
                     pc_ff   <= pc1_ff;
                     neg_ff  <= acc_ff[7];
                     zero_ff <= (acc_ff == '0);
                  end
               endcase
            end
            S_EXEC: begin
               acc_ff   <= alu_y;
               neg_ff   <= alu_y[7];
               zero_ff  <= (alu_y == '0);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  out_acc_ff   <= acc_ff;
                  out_pc_ff    <= pc_ff;
                  out_neg_ff   <= neg_ff;
                  out_zero_ff  <= zero_ff;
                  out_halt_ff  <= halt_ff;
                  out_rd_ff    <= rd_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accumulator     = out_acc_ff;
   assign rsp_chan.program_counter = out_pc_ff;
   assign rsp_chan.negative_flag   = out_neg_ff;
   assign rsp_chan.zero_flag       = out_zero_ff;
   assign rsp_chan.halted          = out_halt_ff;
   assign rsp_chan.read_data       = out_rd_ff;

   `NACC_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_beat, !req_chan.ready, "ready after beat")
   `NACC_ASSERT_NOW(a_halt_keeps_pc, clock, reset, $rose(halt_ff), $stable(pc_ff), "pc moved on hlt")
   `NACC_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "result not from done")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      bit                          drain;
      logic [1:0]                  kind;
      logic [nacc_pkg::ADDR_W-1:0] addr;
      logic [nacc_pkg::DATA_W-1:0] data;
   } cpu_req_type;

   typedef struct {
      logic [nacc_pkg::DATA_W-1:0] acc;
      logic [nacc_pkg::ADDR_W-1:0] pc;
      logic                        n;
      logic                        z;
      logic                        halt;
      logic [nacc_pkg::DATA_W-1:0] rdata;
   } cpu_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nacc_req_if req_chan ();
   nacc_rsp_if rsp_chan ();

   neander_accumulator_cpu_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // predicted machine state
   logic [nacc_pkg::DATA_W-1:0] cpu_mem [nacc_pkg::MEM_DEPTH];
   logic [nacc_pkg::DATA_W-1:0] cpu_acc;
   logic [nacc_pkg::ADDR_W-1:0] cpu_pc;
   logic                        cpu_n;
   logic                        cpu_z;
   logic                        cpu_halt;

   cpu_req_type    pending_reqs[$];
   cpu_status_type expected_states[$];
   int             item_total;
   int             error_count;

   logic [nacc_pkg::DATA_W-1:0] op_table [10] = '{nacc_pkg::OP_NOP, nacc_pkg::OP_STA,
                                                  nacc_pkg::OP_LDA, nacc_pkg::OP_ADD,
                                                  nacc_pkg::OP_OR, nacc_pkg::OP_AND,
                                                  nacc_pkg::OP_NOT, nacc_pkg::OP_JMP,
                                                  nacc_pkg::OP_JN, nacc_pkg::OP_JZ};
   logic [nacc_pkg::DATA_W-1:0] corner_bytes [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};

   initial begin
      foreach (cpu_mem[i]) cpu_mem[i] = '0;
      cpu_acc  = '0;
      cpu_pc   = '0;
      cpu_n    = 1'b0;
      cpu_z    = 1'b0;
      cpu_halt = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic push_req(input logic [1:0] kind, input logic [7:0] addr,
                           input logic [7:0] data);
      cpu_req_type r;
      r.drain = 1'b0;
      r.kind  = kind;
      r.addr  = addr;
      r.data  = data;
      pending_reqs.push_back(r);
      item_total++;
   endtask

   task automatic push_hold();
      cpu_req_type r;
      r.drain = 1'b1;
      r.kind  = nacc_pkg::REQ_READ;
      r.addr  = '0;
      r.data  = '0;
      pending_reqs.push_back(r);
   endtask

   // applies one request to the predicted machine and queues the status it returns
   task automatic run_request(input cpu_req_type r);
      cpu_status_type              s;
      logic [nacc_pkg::DATA_W-1:0] op;
      logic [nacc_pkg::DATA_W-1:0] opnd;
      logic [nacc_pkg::ADDR_W-1:0] opnd_loc;
      logic [nacc_pkg::ADDR_W-1:0] nxt;
      s.rdata = '0;
      case (r.kind)
         nacc_pkg::REQ_WRITE: cpu_mem[r.addr] = r.data;
         nacc_pkg::REQ_READ:  s.rdata = cpu_mem[r.addr];
         nacc_pkg::REQ_START: begin
            cpu_acc  = cpu_mem[nacc_pkg::START_ACC_ADDR];
            cpu_pc   = cpu_mem[nacc_pkg::START_PC_ADDR];
            cpu_n    = 1'b0;
            cpu_z    = 1'b0;
            cpu_halt = 1'b0;
         end
         default: begin
            if (!cpu_halt) begin
               op       = cpu_mem[cpu_pc];
               opnd_loc = cpu_pc + 8'd1;
               opnd     = cpu_mem[opnd_loc];
               nxt      = cpu_pc + 8'd1;
               case (op)
                  nacc_pkg::OP_STA: begin
                     cpu_mem[opnd] = cpu_acc;
                     nxt = cpu_pc + 8'd2;
                  end
                  nacc_pkg::OP_LDA: begin
                     cpu_acc = cpu_mem[opnd];
                     nxt = cpu_pc + 8'd2;
                  end
                  nacc_pkg::OP_ADD: begin
                     cpu_acc = cpu_acc + cpu_mem[opnd];
                     nxt = cpu_pc + 8'd2;
                  end
                  nacc_pkg::OP_OR: begin
                     cpu_acc = cpu_acc | cpu_mem[opnd];
                     nxt = cpu_pc + 8'd2;
                  end
                  nacc_pkg::OP_AND: begin
                     cpu_acc = cpu_acc & cpu_mem[opnd];
                     nxt = cpu_pc + 8'd2;
                  end
                  nacc_pkg::OP_NOT: cpu_acc = ~cpu_acc;
                  nacc_pkg::OP_JMP: nxt = opnd;
                  nacc_pkg::OP_JN:  nxt = cpu_n ? opnd : cpu_pc + 8'd2;
                  nacc_pkg::OP_JZ:  nxt = cpu_z ? opnd : cpu_pc + 8'd2;
                  nacc_pkg::OP_HLT: cpu_halt = 1'b1;
                  default: ;
               endcase
               // hlt leaves pc on its own byte and the flags alone
               if (op != nacc_pkg::OP_HLT) begin
                  cpu_n  = cpu_acc[7];
                  cpu_z  = (cpu_acc == '0);
                  cpu_pc = nxt;
               end
            end
         end
      endcase
      s.acc  = cpu_acc;
      s.pc   = cpu_pc;
      s.n    = cpu_n;
      s.z    = cpu_z;
      s.halt = cpu_halt;
      expected_states.push_back(s);
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.req_type = nacc_pkg::REQ_WRITE;
      req_chan.address  = '0;
      req_chan.data     = '0;
      rsp_chan.ready    = 1'b0;
   end

   // driver
   cpu_req_type cur_req;
   bit          drive_busy;
   int unsigned gap_left;
   int unsigned burst_left;

   always @(posedge clock) begin : driver
      if (reset) begin
         drive_busy   = 1'b0;
         gap_left     = $urandom_range(0, 4);
         burst_left   = $urandom_range(1, 10);
         cur_req.drain = 1'b0;
         cur_req.kind  = nacc_pkg::REQ_WRITE;
         cur_req.addr  = '0;
         cur_req.data  = '0;
         req_chan.valid <= 1'b0;
      end else begin
         if (drive_busy && req_chan.ready) begin
            run_request(cur_req);
            drive_busy = 1'b0;
         end
         if (!drive_busy) begin
            while (pending_reqs.size() > 0 && pending_reqs[0].drain &&
                   expected_states.size() == 0)
               void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && !pending_reqs[0].drain) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  cur_req    = pending_reqs.pop_front();
                  drive_busy = 1'b1;
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(15, 40)
                                                            : $urandom_range(1, 8);
                     gap_left   = $urandom_range(0, 7);
                  end
               end
            end
         end
         req_chan.valid    <= drive_busy;
         req_chan.req_type <= cur_req.kind;
         req_chan.address  <= cur_req.addr;
         req_chan.data     <= cur_req.data;
      end
   end

   // monitor, with a stall pattern whose mode follows bits 8:7 of rx_tick
   int unsigned rx_tick;

   always @(posedge clock) begin : monitor
      cpu_status_type want;
      if (reset) begin
         rx_tick = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_states.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = expected_states.pop_front();
               if (rsp_chan.accumulator !== want.acc)
                  report_mismatch($sformatf("accumulator %h, predicted %h",
                                            rsp_chan.accumulator, want.acc));
               if (rsp_chan.program_counter !== want.pc)
                  report_mismatch($sformatf("program_counter %h, predicted %h",
                                            rsp_chan.program_counter, want.pc));
               if (rsp_chan.negative_flag !== want.n)
                  report_mismatch($sformatf("negative_flag %b, predicted %b",
                                            rsp_chan.negative_flag, want.n));
               if (rsp_chan.zero_flag !== want.z)
                  report_mismatch($sformatf("zero_flag %b, predicted %b",
                                            rsp_chan.zero_flag, want.z));
               if (rsp_chan.halted !== want.halt)
                  report_mismatch($sformatf("halted %b, predicted %b",
                                            rsp_chan.halted, want.halt));
               if (rsp_chan.read_data !== want.rdata)
                  report_mismatch($sformatf("read_data %h, predicted %h",
                                            rsp_chan.read_data, want.rdata));
            end
         end
         rx_tick++;
         case (rx_tick[8:7])
            2'd0:    rsp_chan.ready <= 1'b1;
            2'd1:    rsp_chan.ready <= rx_tick[2:0] != 3'd0;
            2'd2:    rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= rx_tick[3:0] == 4'd0;
         endcase
      end
   end

   initial begin : stimulus
      logic [nacc_pkg::ADDR_W-1:0] base;
      logic [nacc_pkg::ADDR_W-1:0] dbase;
      logic [nacc_pkg::ADDR_W-1:0] loc;
      logic [nacc_pkg::DATA_W-1:0] op;
      logic [nacc_pkg::DATA_W-1:0] opnd;
      logic [nacc_pkg::DATA_W-1:0] val;
      int unsigned                 n_ins;
      int unsigned                 n_steps;
      int unsigned                 episode;

      push_req(nacc_pkg::REQ_READ, 8'h00, 8'hFF);
      push_req(nacc_pkg::REQ_WRITE, 8'hFF, 8'hFF);
      push_req(nacc_pkg::REQ_READ, 8'hFF, 8'h00);
      push_req(nacc_pkg::REQ_STEP, 8'h00, 8'h00);
      push_req(nacc_pkg::REQ_WRITE, nacc_pkg::START_ACC_ADDR, 8'h7F);
      push_req(nacc_pkg::REQ_WRITE, nacc_pkg::START_PC_ADDR, 8'hFC);
      push_req(nacc_pkg::REQ_WRITE, 8'hFC, nacc_pkg::OP_ADD);
      push_req(nacc_pkg::REQ_WRITE, 8'hFD, 8'h03);
      push_req(nacc_pkg::REQ_WRITE, 8'h03, 8'h81);
      push_req(nacc_pkg::REQ_WRITE, 8'hFE, nacc_pkg::OP_JN);
      push_req(nacc_pkg::REQ_WRITE, 8'h00, nacc_pkg::OP_JZ);
      push_req(nacc_pkg::REQ_WRITE, 8'h7F, nacc_pkg::OP_NOT);
      push_req(nacc_pkg::REQ_WRITE, 8'h80, nacc_pkg::OP_HLT);
      push_req(nacc_pkg::REQ_START, 8'hFF, 8'hFF);
      // add wraps to zero, untaken jn wraps pc to 00, taken jz, not, halt
      push_req(nacc_pkg::REQ_STEP, 8'hFF, 8'h00);
      push_req(nacc_pkg::REQ_STEP, 8'h00, 8'hFF);
      push_req(nacc_pkg::REQ_STEP, 8'h55, 8'hAA);
      push_req(nacc_pkg::REQ_STEP, 8'hAA, 8'h55);
      push_req(nacc_pkg::REQ_STEP, 8'h00, 8'h00);
      push_req(nacc_pkg::REQ_STEP, 8'h00, 8'h00);
      push_req(nacc_pkg::REQ_READ, 8'h03, 8'h00);
      push_hold();

      episode = 0;
      while (item_total < 650) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               push_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end else begin
            base  = 8'($urandom);
            dbase = 8'($urandom);
            for (int k = 0; k < 8; k++) begin
               val = $urandom_range(0, 3) == 0 ? corner_bytes[3'($urandom_range(0, 4))]
                                               : 8'($urandom);
               push_req(nacc_pkg::REQ_WRITE, dbase + 8'(k), val);
            end
            push_req(nacc_pkg::REQ_WRITE, nacc_pkg::START_ACC_ADDR,
                     $urandom_range(0, 3) == 0 ? corner_bytes[3'($urandom_range(0, 4))]
                                               : 8'($urandom));
            push_req(nacc_pkg::REQ_WRITE, nacc_pkg::START_PC_ADDR, base);
            n_ins = $urandom_range(3, 10);
            loc   = base;
            for (int k = 0; k < n_ins; k++) begin
               case ($urandom_range(0, 15))
                  15:      op = 8'($urandom);
                  14:      op = nacc_pkg::OP_HLT;
                  default: op = op_table[4'($urandom_range(0, 9))];
               endcase
               push_req(nacc_pkg::REQ_WRITE, loc, op);
               loc = loc + 8'd1;
               if (op == nacc_pkg::OP_JMP || op == nacc_pkg::OP_JN ||
                   op == nacc_pkg::OP_JZ) begin
                  opnd = base + 8'($urandom_range(0, 2 * n_ins));
                  push_req(nacc_pkg::REQ_WRITE, loc, opnd);
                  loc = loc + 8'd1;
               end else if (op == nacc_pkg::OP_STA || op == nacc_pkg::OP_LDA ||
                            op == nacc_pkg::OP_ADD || op == nacc_pkg::OP_OR ||
                            op == nacc_pkg::OP_AND) begin
                  opnd = dbase + 8'($urandom_range(0, 7));
                  push_req(nacc_pkg::REQ_WRITE, loc, opnd);
                  loc = loc + 8'd1;
               end
            end
            push_req(nacc_pkg::REQ_START, 8'($urandom), 8'($urandom));
            n_steps = $urandom_range(n_ins, 2 * n_ins + 4);
            repeat (n_steps) begin
               if ($urandom_range(0, 5) == 0)
                  push_req(nacc_pkg::REQ_READ, dbase + 8'($urandom_range(0, 7)),
                           8'($urandom));
               push_req(nacc_pkg::REQ_STEP, 8'($urandom), 8'($urandom));
            end
         end
         episode++;
         if (episode % 5 == 0)
            push_hold();
      end

      while (pending_reqs.size() != 0 || drive_busy || expected_states.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
